// ===== rtl/sed_pkg.sv =====
// Shared constants, payload types and control codes of the Sobel edge detector.
package sed_pkg;

    // Line buffer depth and the address width that follows from it.
    localparam int MAX_WIDTH = 2048;
    localparam int LINE_AW   = $clog2(MAX_WIDTH);

    // Field widths.
    localparam int PIX_W     = 8;
    localparam int COL_W     = 12;
    localparam int ROW_W     = 16;
    localparam int OUT_COL_W = 11;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Shared multiplier and iterative square root.
    localparam int MUL_W      = 16;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int RAD_W      = 34;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int STEP_W     = $clog2(ROOT_W);
    localparam int REM_W      = ROOT_W + 1;
    localparam int GRAD_W     = 10;

    // Luma weights in Q0.16.
    localparam logic [MUL_W-1:0] W_RED   = 16'd19595;
    localparam logic [MUL_W-1:0] W_GREEN = 16'd38470;
    localparam logic [MUL_W-1:0] W_BLUE  = 16'd7471;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0]     edge_value;
        logic [OUT_COL_W-1:0] column;
        logic [ROW_W-1:0]     row;
        logic                 frame_done;
    } result_t;

    typedef struct packed {
        logic [COL_W-1:0] image_width;
        logic [ROW_W-1:0] image_height;
        logic             restart;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GRAY_MUL,
        ST_GRAY_ROOT,
        ST_GRAD,
        ST_MAG_MUL,
        ST_MAG_ROOT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        PH_SQ_R,
        PH_WT_R,
        PH_SQ_G,
        PH_WT_G,
        PH_SQ_B,
        PH_WT_B,
        PH_ROOT
    } phase_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

endpackage

// ===== rtl/sed_cfg_regs.sv =====
// Configuration registers of the Sobel edge detector behind a simple APB-style port.
module sed_cfg_regs import sed_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [COL_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    logic             wr_en;
    reg_idx_t         idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= '0;
            height_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[COL_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // Any write restarts the frame in the same cycle as the register update.
    assign cfg.image_width  = width_reg;
    assign cfg.image_height = height_reg;
    assign cfg.restart      = wr_en;

endmodule

// ===== rtl/sed_line_mem.sv =====
// Line buffer memory: both gray rows share one word, read through an output register.
module sed_line_mem import sed_pkg::*; (
    input  logic                 aclk,
    input  logic [LINE_AW-1:0]   addr,
    input  logic                 wr_en,
    input  logic [2*PIX_W-1:0]   wr_data,
    output logic [2*PIX_W-1:0]   rd_data
);

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sed_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module sed_isqrt import sed_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_W - 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              fits;

    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = (REM_W+2)'({root_reg, 2'b01});
    assign fits   = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits) begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("root reported while the unit is still iterating");

    a_start_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start && !busy_reg |=> busy_reg && cnt_reg == '0)
        else $error("start did not launch a fresh root");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg == LAST_STEP |=> done_reg && !busy_reg)
        else $error("root not reported after its last step");

endmodule

// ===== rtl/sobel_edge_detector.sv =====
// Top level of the Sobel edge detector: sequencer, window, counters and result register.
//
//  Channel   Direction  Handshake            Beat payload
//  s_*       in         s_valid / s_ready    pixel_t: red, green, blue
//  m_*       out        m_valid / m_ready    result_t: edge_value, column, row, frame_done
//  p*        in/out     APB-style, pready=1  image_width (0x0), image_height (0x4)
//
// Each pixel is worked on alone. The shared 16x16 multiplier forms the weighted sum of
// squares and the one-bit-per-cycle root unit takes its root; an interior pixel adds the
// gradient, two squares and a second root. The next beat is taken once a pixel is done.
// The two gray rows live in one memory word per column, read ahead of use and
// written back in the final cycle of the pixel, so no two accesses to an entry overlap.
// Reset clears the counters, the window and the sequencer; the line memory keeps whatever
// it holds. A full result register holds the next pixel only at its final cycle, and only
// if that pixel has a result to deliver; input beats are taken while a result waits.
module sobel_edge_detector import sed_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // pixel input
    input  logic               s_valid,
    output logic               s_ready,
    input  pixel_t             s_data,
    // edge result output
    output logic               m_valid,
    input  logic               m_ready,
    output result_t            m_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t      cfg;
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    // Control from the output decoder.
    logic             fin_go;
    acc_op_t          acc_op;
    logic [MUL_W-1:0] mul_a;
    logic [MUL_W-1:0] mul_b;

    // Position in the frame and the six-pixel history of the window.
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [PIX_W-1:0] win_reg [6];

    // Per-pixel working registers.
    pixel_t            pix_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [RAD_W-1:0]  acc_reg;
    logic [PIX_W-1:0]  gray_reg;
    logic [GRAD_W-1:0] ax_reg;
    logic [GRAD_W-1:0] ay_reg;
    logic [PIX_W-1:0]  mag_reg;

    logic              m_valid_reg;
    result_t           m_data_reg;

    // Line memory access.
    logic [LINE_AW-1:0]  line_addr;
    logic [2*PIX_W-1:0]  line_rd;
    logic [PIX_W-1:0]    top_pix;
    logic [PIX_W-1:0]    mid_pix;

    // Frame geometry.
    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic             emit;
    logic             last_col;
    logic             last_row;
    logic             frame_end;

    // Gradient terms.
    logic [GRAD_W-1:0] sx_pos, sx_neg, sy_pos, sy_neg;
    logic [GRAD_W:0]   gx_diff, gy_diff;
    logic [GRAD_W-1:0] ax_abs, ay_abs;
    logic [PIX_W-1:0]  gray_root, mag_root;

    sed_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sed_line_mem u_line (
        .aclk    (aclk),
        .addr    (line_addr),
        .wr_en   (fin_go),
        .wr_data ({mid_pix, gray_reg}),
        .rd_data (line_rd)
    );

    sed_isqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .rsp     (sqrt_rsp)
    );

    // Widths beyond the line memory fold to its depth.
    assign w_eff = (32'(cfg.image_width) > MAX_WIDTH) ? COL_W'(MAX_WIDTH) : cfg.image_width;
    assign h_eff = cfg.image_height;

    // The column counter never leaves the memory range, but the address is clamped anyway.
    assign line_addr = (32'(col_reg) < MAX_WIDTH) ? LINE_AW'(col_reg)
                                                  : LINE_AW'(MAX_WIDTH - 1);

    // Upper byte holds the row two above, lower byte the row just above.
    assign top_pix = line_rd[2*PIX_W-1:PIX_W];
    assign mid_pix = line_rd[PIX_W-1:0];

    // A result belongs to the pixel one row up and one column left of the current one.
    assign emit = (w_eff > COL_W'(2)) && (h_eff > ROW_W'(2)) &&
                  (col_reg >= COL_W'(2)) && (col_reg < w_eff) &&
                  (row_reg >= ROW_W'(2)) && (row_reg < h_eff);

    assign frame_end = (col_reg == COL_W'(w_eff - 1'b1)) &&
                       (row_reg == ROW_W'(h_eff - 1'b1));

    assign last_col = ({1'b0, col_reg} + 1'b1) >= {1'b0, w_eff};
    assign last_row = ({1'b0, row_reg} + 1'b1) >= {1'b0, h_eff};

    // Sobel sums: window columns are older (0..2) and middle (3..5); the newest column
    // comes from the line memory and the fresh gray value.
    assign sx_pos = {2'b00, top_pix} + {1'b0, mid_pix, 1'b0} + {2'b00, gray_reg};
    assign sx_neg = {2'b00, win_reg[0]} + {1'b0, win_reg[1], 1'b0} + {2'b00, win_reg[2]};
    assign sy_pos = {2'b00, win_reg[2]} + {1'b0, win_reg[5], 1'b0} + {2'b00, gray_reg};
    assign sy_neg = {2'b00, win_reg[0]} + {1'b0, win_reg[3], 1'b0} + {2'b00, top_pix};

    assign gx_diff = {1'b0, sx_pos} - {1'b0, sx_neg};
    assign gy_diff = {1'b0, sy_pos} - {1'b0, sy_neg};
    assign ax_abs  = gx_diff[GRAD_W] ? GRAD_W'(-gx_diff) : gx_diff[GRAD_W-1:0];
    assign ay_abs  = gy_diff[GRAD_W] ? GRAD_W'(-gy_diff) : gy_diff[GRAD_W-1:0];

    // Gray is the root scaled down by 256; both values saturate at full scale.
    assign gray_root = sqrt_rsp.root[ROOT_W-1] ? PIX_MAX : sqrt_rsp.root[ROOT_W-2:PIX_W];
    assign mag_root  = (|sqrt_rsp.root[ROOT_W-1:PIX_W]) ? PIX_MAX
                                                        : sqrt_rsp.root[PIX_W-1:0];

    // Next state and next phase.
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_GRAY_MUL;
                    phase_next = PH_SQ_R;
                end
            end
            ST_GRAY_MUL: begin
                if (phase_reg == PH_ROOT) begin
                    state_next = ST_GRAY_ROOT;
                end else begin
                    phase_next = phase_t'(phase_reg + 1'b1);
                end
            end
            ST_GRAY_ROOT: begin
                if (sqrt_rsp.done) begin
                    state_next = emit ? ST_GRAD : ST_FINISH;
                end
            end
            ST_GRAD: begin
                state_next = ST_MAG_MUL;
                phase_next = PH_SQ_R;
            end
            ST_MAG_MUL: begin
                case (phase_reg)
                    PH_SQ_R: phase_next = PH_SQ_G;
                    PH_SQ_G: phase_next = PH_ROOT;
                    default: state_next = ST_MAG_ROOT;
                endcase
            end
            ST_MAG_ROOT: begin
                if (sqrt_rsp.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (fin_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: input ready, multiplier operands, accumulator, root launch and finish.
    always_comb begin
        s_ready           = 1'b0;
        fin_go            = 1'b0;
        acc_op            = ACC_HOLD;
        mul_a             = '0;
        mul_b             = '0;
        sqrt_req.start    = 1'b0;
        sqrt_req.radicand = acc_reg + RAD_W'(prod_reg);
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_GRAY_MUL: begin
                case (phase_reg)
                    PH_SQ_R: begin
                        mul_a = MUL_W'(pix_reg.red);
                        mul_b = MUL_W'(pix_reg.red);
                    end
                    PH_WT_R: begin
                        mul_a = W_RED;
                        mul_b = prod_reg[MUL_W-1:0];
                    end
                    PH_SQ_G: begin
                        acc_op = ACC_LOAD;
                        mul_a  = MUL_W'(pix_reg.green);
                        mul_b  = MUL_W'(pix_reg.green);
                    end
                    PH_WT_G: begin
                        mul_a = W_GREEN;
                        mul_b = prod_reg[MUL_W-1:0];
                    end
                    PH_SQ_B: begin
                        acc_op = ACC_ADD;
                        mul_a  = MUL_W'(pix_reg.blue);
                        mul_b  = MUL_W'(pix_reg.blue);
                    end
                    PH_WT_B: begin
                        mul_a = W_BLUE;
                        mul_b = prod_reg[MUL_W-1:0];
                    end
                    default: sqrt_req.start = 1'b1;
                endcase
            end
            ST_MAG_MUL: begin
                case (phase_reg)
                    PH_SQ_R: begin
                        mul_a = MUL_W'(ax_reg);
                        mul_b = MUL_W'(ax_reg);
                    end
                    PH_SQ_G: begin
                        acc_op = ACC_LOAD;
                        mul_a  = MUL_W'(ay_reg);
                        mul_b  = MUL_W'(ay_reg);
                    end
                    default: sqrt_req.start = 1'b1;
                endcase
            end
            ST_FINISH: begin
                // Hold the pixel while its result cannot be placed.
                fin_go = !emit || !m_valid_reg || m_ready;
            end
            default: ;
        endcase
    end

    // Control state: sequencer, counters, window and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_SQ_R;
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;

            if (fin_go && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg.restart) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (fin_go) begin
                if (last_col) begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : ROW_W'(row_reg + 1'b1);
                end else begin
                    col_reg <= COL_W'(col_reg + 1'b1);
                end
            end

            if (fin_go) begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top_pix;
                win_reg[4] <= mid_pix;
                win_reg[5] <= gray_reg;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pix_reg <= s_data;
        end

        prod_reg <= mul_a * mul_b;

        case (acc_op)
            ACC_LOAD: acc_reg <= RAD_W'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + RAD_W'(prod_reg);
            default:  ;
        endcase

        if (state_reg == ST_GRAY_ROOT && sqrt_rsp.done) begin
            gray_reg <= gray_root;
        end
        if (state_reg == ST_MAG_ROOT && sqrt_rsp.done) begin
            mag_reg <= mag_root;
        end
        if (state_reg == ST_GRAD) begin
            ax_reg <= ax_abs;
            ay_reg <= ay_abs;
        end

        if (fin_go && emit) begin
            m_data_reg.edge_value <= mag_reg;
            m_data_reg.column     <= OUT_COL_W'(col_reg - 1'b1);
            m_data_reg.row        <= ROW_W'(row_reg - 1'b1);
            m_data_reg.frame_done <= frame_end;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_root_when_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_rsp.done |-> (state_reg == ST_GRAY_ROOT || state_reg == ST_MAG_ROOT))
        else $error("square root finished while the sequencer was not waiting for it");

    a_grad_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_GRAD |-> emit)
        else $error("gradient computed for a pixel that yields no result");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_GRAY_MUL && phase_reg == PH_SQ_R)
        else $error("accepted beat did not start the gray computation");

endmodule
